FILE: hdl/acs_pkg.sv
// shared constants, types and helpers for the accelerometer correct and smooth unit
package acs_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;
    localparam int RAW_W     = 16;
    localparam int ACC_W     = 24;
    localparam int DIF_W     = 25;
    localparam int MB_W      = 23;
    localparam int PRD_W     = 48;
    localparam int WGT_W     = 16;
    localparam int THR_W     = 23;
    localparam int BIAS_W    = 17;
    localparam int GAIN_W    = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_BIAS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BIAS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Z_BIAS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN = 3'd7;

    // register reset values
    localparam logic [WGT_W-1:0]  RST_WEIGHT = 16'd25892;
    localparam logic [THR_W-1:0]  RST_THRESH = 23'd327680;
    localparam logic [BIAS_W-1:0] RST_X_BIAS = 17'd19045;
    localparam logic [GAIN_W-1:0] RST_X_GAIN = 17'd65416;
    localparam logic [BIAS_W-1:0] RST_Y_BIAS = 17'h1E1E2;
    localparam logic [GAIN_W-1:0] RST_Y_GAIN = 17'd65392;
    localparam logic [BIAS_W-1:0] RST_Z_BIAS = 17'd24268;
    localparam logic [GAIN_W-1:0] RST_Z_GAIN = 17'd65092;

    // q.32 constants: 9.81/16384, 0.15, 0.01
    localparam logic signed [MB_W-1:0] CNT_SCALE_Q32 = 23'sd2571633;
    localparam longint OFS_015_Q32 = 64'd644245094;
    localparam longint OFS_001_Q32 = 64'd42949673;

    localparam logic signed [PRD_W-1:0] SAT_MAX = 48'sd8388607;
    localparam logic signed [PRD_W-1:0] SAT_MIN = -48'sd8388608;

    typedef struct packed {
        logic [WGT_W-1:0]                 weight;
        logic [THR_W-1:0]                 thresh;
        logic [NUM_AXES-1:0][BIAS_W-1:0]  bias;
        logic [NUM_AXES-1:0][GAIN_W-1:0]  gain;
    } t_cfg;

    function automatic logic signed [ACC_W-1:0] sat24(input logic signed [PRD_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[ACC_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/accel_correct_and_smooth_unit.sv
// top level of the accelerometer correct and smooth unit
//
// usage: one item is a three-axis raw sample (i_raw_x/y/z, signed counts),
// taken on i_valid & o_ready. each axis is scaled to q.FRAC_BITS m/s^2,
// bias and gain corrected above the threshold or offset corrected otherwise,
// and then folded into a per-axis exponential moving average.
// the result item (o_corrected_*, o_smoothed_*) is shown on o_valid and
// taken on o_valid & i_ready.
// one 25x23 multiplier and one add/saturate path are shared under a
// sequencer that walks the three axes in turn: on the offset path an axis
// goes through scale, round, compare, filter difference, multiply, round and
// update; the gain path adds a gain multiply and round after the compare; a
// done state then hands off the result. o_ready rises with o_valid, so the
// next item is taken only after the last one has been handed off.
// the result sits in an output register: a stalled receiver does not block
// the next item, which is held at its hand-off until the older one is taken.
// configuration writes (i_cfg_valid, i_cfg_index, i_cfg_data) are always
// accepted and are meant to happen only while the unit is idle.
// reset (i_rst_n low, synchronous) restores register defaults, clears the
// filter state and drops o_valid.
module accel_correct_and_smooth_unit
    import acs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [RAW_W-1:0]     i_raw_x,
    input  logic signed [RAW_W-1:0]     i_raw_y,
    input  logic signed [RAW_W-1:0]     i_raw_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [ACC_W-1:0]     o_corrected_x,
    output logic signed [ACC_W-1:0]     o_corrected_y,
    output logic signed [ACC_W-1:0]     o_corrected_z,
    output logic signed [ACC_W-1:0]     o_smoothed_x,
    output logic signed [ACC_W-1:0]     o_smoothed_y,
    output logic signed [ACC_W-1:0]     o_smoothed_z
);

    localparam int SC = 32 - FRAC_BITS;
    localparam logic signed [PRD_W-1:0] RND_SC = PRD_W'(64'd1 << (SC - 1));
    localparam logic signed [PRD_W-1:0] RND_16 = PRD_W'(64'd1 << 15);
    localparam logic signed [DIF_W-1:0] OFS_XZ =
        DIF_W'((OFS_015_Q32 + (64'd1 << (SC - 1))) >> SC);
    localparam logic signed [DIF_W-1:0] OFS_Y =
        DIF_W'((OFS_001_Q32 + (64'd1 << (SC - 1))) >> SC);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_VRND  = 4'd2;
    localparam logic [3:0] ST_CMP   = 4'd3;
    localparam logic [3:0] ST_GAIN  = 4'd4;
    localparam logic [3:0] ST_GRND  = 4'd5;
    localparam logic [3:0] ST_EDIF  = 4'd6;
    localparam logic [3:0] ST_EMUL  = 4'd7;
    localparam logic [3:0] ST_ERND  = 4'd8;
    localparam logic [3:0] ST_EUPD  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    t_cfg w_cfg;

    logic [3:0]                r_state, n_state;
    logic [1:0]                r_axis, n_axis;
    logic                      r_ovalid, n_ovalid;
    logic signed [ACC_W-1:0]   r_filt [NUM_AXES];
    logic signed [ACC_W-1:0]   r_corr [NUM_AXES];
    logic signed [RAW_W-1:0]   r_raw  [NUM_AXES];
    logic signed [PRD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_v;
    logic signed [DIF_W-1:0]   r_diff;
    logic signed [ACC_W-1:0]   r_out_c [NUM_AXES];
    logic signed [ACC_W-1:0]   r_out_s [NUM_AXES];

    logic signed [DIF_W-1:0]   mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PRD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]   thr_ext;
    logic signed [DIF_W-1:0]   ofs_sel;
    logic                      in_acc;
    logic                      out_load;

    acs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign out_load    = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    // shared multiplier operands
    always_comb begin
        case (r_state)
            ST_GAIN: begin
                mul_a = r_diff;
                mul_b = MB_W'($signed({1'b0, w_cfg.gain[r_axis]}));
            end
            ST_EMUL: begin
                mul_a = r_diff;
                mul_b = MB_W'($signed({1'b0, w_cfg.weight}));
            end
            default: begin
                mul_a = DIF_W'(r_raw[r_axis]);
                mul_b = CNT_SCALE_Q32;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign thr_ext = $signed({1'b0, w_cfg.thresh});
    assign ofs_sel = (r_axis == AX_Y) ? OFS_Y : OFS_XZ;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCALE;
                    n_axis  = AX_X;
                end
            end
            ST_SCALE: n_state = ST_VRND;
            ST_VRND:  n_state = ST_CMP;
            ST_CMP:   n_state = (r_v > thr_ext) ? ST_GAIN : ST_EDIF;
            ST_GAIN:  n_state = ST_GRND;
            ST_GRND:  n_state = ST_EDIF;
            ST_EDIF:  n_state = ST_EMUL;
            ST_EMUL:  n_state = ST_ERND;
            ST_ERND:  n_state = ST_EUPD;
            ST_EUPD: begin
                if (r_axis == AX_Z) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCALE;
                    n_axis  = r_axis + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_axis   <= AX_X;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_filt[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
            if (r_state == ST_EUPD) begin
                r_filt[r_axis] <= sat24(PRD_W'(r_filt[r_axis]) + PRD_W'(r_diff));
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw[0] <= i_raw_x;
            r_raw[1] <= i_raw_y;
            r_raw[2] <= i_raw_z;
        end
        case (r_state)
            ST_SCALE, ST_GAIN, ST_EMUL: r_prod <= mul_p;
            ST_VRND: r_v <= sat24((r_prod + RND_SC) >>> SC);
            ST_CMP: begin
                if (r_v > thr_ext) begin
                    r_diff <= DIF_W'(r_v) - DIF_W'($signed(w_cfg.bias[r_axis]));
                end else begin
                    r_corr[r_axis] <= sat24(PRD_W'(r_v) - PRD_W'(ofs_sel));
                end
            end
            ST_GRND: r_corr[r_axis] <= sat24((r_prod + RND_16) >>> 16);
            ST_EDIF: r_diff <= DIF_W'(r_corr[r_axis]) - DIF_W'(r_filt[r_axis]);
            ST_ERND: r_diff <= DIF_W'((r_prod + RND_16) >>> 16);
            default: ;
        endcase
        if (out_load) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_out_c[i] <= r_corr[i];
                r_out_s[i] <= r_filt[i];
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_corrected_x = r_out_c[0];
    assign o_corrected_y = r_out_c[1];
    assign o_corrected_z = r_out_c[2];
    assign o_smoothed_x  = r_out_s[0];
    assign o_smoothed_y  = r_out_s[1];
    assign o_smoothed_z  = r_out_s[2];

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("unit still ready after taking an item");

    a_filter_only_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EUPD) |=> ($stable(r_filt[0]) && $stable(r_filt[1])
                                  && $stable(r_filt[2])))
        else $error("filter state changed outside its update step");

    a_hold_done_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ovalid && !i_ready) |=> (r_state == ST_DONE))
        else $error("finished item overwrote a pending result");

    a_axis_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EUPD) |-> (r_axis == AX_X || r_axis == AX_Y || r_axis == AX_Z))
        else $error("axis counter out of range");
`endif

endmodule

FILE: hdl/acs_cfg_regs.sv
// configuration register file for the correct and smooth unit
module acs_cfg_regs
    import acs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight  <= RST_WEIGHT;
            r_cfg.thresh  <= RST_THRESH;
            r_cfg.bias[0] <= RST_X_BIAS;
            r_cfg.gain[0] <= RST_X_GAIN;
            r_cfg.bias[1] <= RST_Y_BIAS;
            r_cfg.gain[1] <= RST_Y_GAIN;
            r_cfg.bias[2] <= RST_Z_BIAS;
            r_cfg.gain[2] <= RST_Z_GAIN;
        end else if (i_wr_en) begin
            case (i_index)
                REG_WEIGHT: r_cfg.weight  <= i_data[WGT_W-1:0];
                REG_THRESH: r_cfg.thresh  <= i_data[THR_W-1:0];
                REG_X_BIAS: r_cfg.bias[0] <= i_data[BIAS_W-1:0];
                REG_X_GAIN: r_cfg.gain[0] <= i_data[GAIN_W-1:0];
                REG_Y_BIAS: r_cfg.bias[1] <= i_data[BIAS_W-1:0];
                REG_Y_GAIN: r_cfg.gain[1] <= i_data[GAIN_W-1:0];
                REG_Z_BIAS: r_cfg.bias[2] <= i_data[BIAS_W-1:0];
                REG_Z_GAIN: r_cfg.gain[2] <= i_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: tb/testbench.sv
// testbench for the accelerometer correct and smooth unit: checks every result against a predictor
module testbench;
    import acs_pkg::*;

    localparam longint COUNT_SCALE_Q32 = 2571633;
    localparam longint OFFSET_XZ_Q32   = 644245094;
    localparam longint OFFSET_Y_Q32    = 42949673;
    localparam int     COUNT_SHIFT     = 32 - FRAC_BITS_DEF;
    localparam int     UNIT_SHIFT      = 16;

    localparam logic [WGT_W-1:0]         RESET_WEIGHT = 16'd25892;
    localparam logic [THR_W-1:0]         RESET_THRESH = 23'd327680;
    localparam logic signed [BIAS_W-1:0] RESET_X_BIAS = 17'sd19045;
    localparam logic [GAIN_W-1:0]        RESET_X_GAIN = 17'd65416;
    localparam logic signed [BIAS_W-1:0] RESET_Y_BIAS = -17'sd7710;
    localparam logic [GAIN_W-1:0]        RESET_Y_GAIN = 17'd65392;
    localparam logic signed [BIAS_W-1:0] RESET_Z_BIAS = 17'sd24268;
    localparam logic [GAIN_W-1:0]        RESET_Z_GAIN = 17'd65092;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 192;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic signed [ACC_W-1:0] corr [NUM_AXES];
        logic signed [ACC_W-1:0] filt [NUM_AXES];
    } t_accel_result;

    class correction_tracker;
        logic [WGT_W-1:0]         weight;
        logic [THR_W-1:0]         thresh;
        logic signed [BIAS_W-1:0] bias [NUM_AXES];
        logic [GAIN_W-1:0]        gain [NUM_AXES];
        longint                   filt [NUM_AXES];
        t_accel_result            expected_results [$];
        int mismatches;
        int samples;
        int gain_path;
        int offset_path;

        function new();
            weight  = RESET_WEIGHT;
            thresh  = RESET_THRESH;
            bias[0] = RESET_X_BIAS;
            gain[0] = RESET_X_GAIN;
            bias[1] = RESET_Y_BIAS;
            gain[1] = RESET_Y_GAIN;
            bias[2] = RESET_Z_BIAS;
            gain[2] = RESET_Z_GAIN;
            foreach (filt[a]) filt[a] = 0;
            mismatches  = 0;
            samples     = 0;
            gain_path   = 0;
            offset_path = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_WEIGHT: weight  = data[WGT_W-1:0];
                REG_THRESH: thresh  = data[THR_W-1:0];
                REG_X_BIAS: bias[0] = data[BIAS_W-1:0];
                REG_X_GAIN: gain[0] = data[GAIN_W-1:0];
                REG_Y_BIAS: bias[1] = data[BIAS_W-1:0];
                REG_Y_GAIN: gain[1] = data[GAIN_W-1:0];
                REG_Z_BIAS: bias[2] = data[BIAS_W-1:0];
                REG_Z_GAIN: gain[2] = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // round to nearest, ties up
        function longint round_q(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clamp24(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        function longint scale_counts(logic signed [RAW_W-1:0] r);
            return clamp24(round_q(longint'(r) * COUNT_SCALE_Q32, COUNT_SHIFT));
        endfunction

        function longint corrected_axis(int a, logic signed [RAW_W-1:0] r);
            longint v;
            longint ofs;
            v = scale_counts(r);
            if (v > longint'(thresh)) begin
                gain_path++;
                return clamp24(round_q((v - longint'(bias[a])) * longint'(gain[a]), UNIT_SHIFT));
            end
            offset_path++;
            ofs = (a == 1) ? OFFSET_Y_Q32 : OFFSET_XZ_Q32;
            return clamp24(v - round_q(ofs, COUNT_SHIFT));
        endfunction

        function void note_sample(logic signed [RAW_W-1:0] x, y, z);
            logic signed [RAW_W-1:0] raw [NUM_AXES];
            t_accel_result want;
            longint c;
            raw[0] = x;
            raw[1] = y;
            raw[2] = z;
            for (int a = 0; a < NUM_AXES; a++) begin
                c = corrected_axis(a, raw[a]);
                filt[a] = clamp24(filt[a] + round_q((c - filt[a]) * longint'(weight), UNIT_SHIFT));
                want.corr[a] = c[ACC_W-1:0];
                want.filt[a] = filt[a][ACC_W-1:0];
            end
            expected_results.push_back(want);
            samples++;
        endfunction

        function void report(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s at item %0d: expected %0d, got %0d",
                         field, samples - expected_results.size(), want, got);
            end
        endfunction

        function void check_result(t_accel_result got);
            t_accel_result want;
            string tags;
            tags = "xyz";
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result item with no sample pending");
                return;
            end
            want = expected_results.pop_front();
            for (int a = 0; a < NUM_AXES; a++) begin
                if (got.corr[a] !== want.corr[a])
                    report({"corrected_", tags.substr(a, a)},
                           longint'(want.corr[a]), longint'(got.corr[a]));
                if (got.filt[a] !== want.filt[a])
                    report({"smoothed_", tags.substr(a, a)},
                           longint'(want.filt[a]), longint'(got.filt[a]));
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]     i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [RAW_W-1:0]  i_raw_x = '0;
    logic signed [RAW_W-1:0]  i_raw_y = '0;
    logic signed [RAW_W-1:0]  i_raw_z = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [ACC_W-1:0]  o_corrected_x;
    logic signed [ACC_W-1:0]  o_corrected_y;
    logic signed [ACC_W-1:0]  o_corrected_z;
    logic signed [ACC_W-1:0]  o_smoothed_x;
    logic signed [ACC_W-1:0]  o_smoothed_y;
    logic signed [ACC_W-1:0]  o_smoothed_z;

    correction_tracker tracker;
    t_accel_result     seen_result;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int settings_used = 0;

    accel_correct_and_smooth_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .i_raw_z       (i_raw_z),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_corrected_x (o_corrected_x),
        .o_corrected_y (o_corrected_y),
        .o_corrected_z (o_corrected_z),
        .o_smoothed_x  (o_smoothed_x),
        .o_smoothed_y  (o_smoothed_y),
        .o_smoothed_z  (o_smoothed_z)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 2000000);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.corr[0] = o_corrected_x;
            seen_result.corr[1] = o_corrected_y;
            seen_result.corr[2] = o_corrected_z;
            seen_result.filt[0] = o_smoothed_x;
            seen_result.filt[1] = o_smoothed_y;
            seen_result.filt[2] = o_smoothed_z;
            tracker.check_result(seen_result);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic set_all(input logic [CFG_DAT_W-1:0] w, t, bx, gx, by, gy, bz, gz);
        cfg_write(REG_WEIGHT, w);
        cfg_write(REG_THRESH, t);
        cfg_write(REG_X_BIAS, bx);
        cfg_write(REG_X_GAIN, gx);
        cfg_write(REG_Y_BIAS, by);
        cfg_write(REG_Y_GAIN, gy);
        cfg_write(REG_Z_BIAS, bz);
        cfg_write(REG_Z_GAIN, gz);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic offer_sample(input logic signed [RAW_W-1:0] x, y, z);
        i_valid <= 1'b1;
        i_raw_x <= x;
        i_raw_y <= y;
        i_raw_z <= z;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_sample(x, y, z);
    endtask

    task automatic idle_gap();
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // mostly full-range counts, some extremes, some right at the threshold
    function automatic logic signed [RAW_W-1:0] pick_raw();
        longint near_thr;
        int     sel;
        logic signed [RAW_W-1:0] r;
        sel = $urandom_range(15);
        near_thr = (longint'(tracker.thresh) << COUNT_SHIFT) / COUNT_SCALE_Q32;
        r = RAW_W'($urandom());
        if (sel == 0) begin
            case ($urandom_range(3))
                0: r = 16'sh7FFF;
                1: r = 16'sh8000;
                2: r = 16'sh0000;
                default: r = 16'shFFFF;
            endcase
        end else if (sel < 4 && near_thr <= 32766) begin
            r = RAW_W'(near_thr + longint'($urandom_range(2)) - 1);
        end
        return r;
    endfunction

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings
        offer_sample(0, 0, 0);
        offer_sample(32767, 32767, 32767);
        offer_sample(-32768, -32768, -32768);
        offer_sample(1, -1, 0);
        offer_sample(16384, 16384, 16384);
        offer_sample(8352, -8352, 100);
        offer_sample(-1, 32767, -32768);

        // full weight, zero threshold, most negative bias, largest gain
        wait_drained();
        set_all(23'h7FFFFF, 23'h000000, 23'h7F0000, 23'h7FFFFF,
                23'h7F0000, 23'h7FFFFF, 23'h7F0000, 23'h7FFFFF);
        offer_sample(0, 0, 0);
        offer_sample(1, 1, 1);
        offer_sample(32767, -32768, 12345);

        // scaled value equal to the threshold, just above and just below
        wait_drained();
        cfg_write(REG_THRESH, CFG_DAT_W'(tracker.scale_counts(8000)));
        i_cfg_valid <= 1'b0;
        offer_sample(8000, 8000, 8000);
        offer_sample(8001, 7999, 8000);

        // zero weight, top threshold, largest bias, zero gain
        wait_drained();
        set_all(23'h7F0000, 23'h7FFFFF, 23'h00FFFF, 23'h7E0000,
                23'h00FFFF, 23'h7E0000, 23'h00FFFF, 23'h7E0000);
        offer_sample(32767, -32768, 0);
        offer_sample(100, 200, 300);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            set_all(CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom_range(1400000)),
                    CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom()),
                    CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom()),
                    CFG_DAT_W'($urandom()), CFG_DAT_W'($urandom()));
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                default: begin
                    send_idle_pct = 6;
                    stall_pct = 6;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && p % 4 == 0) hold_request = HOLD_CYCLES;
                if (n == PHASE_ITEMS / 2 && p % 4 == 1) wait_drained();
                idle_gap();
                offer_sample(pick_raw(), pick_raw(), pick_raw());
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        tracker.mismatches += tracker.pending();

        $display("%0d samples over %0d register settings: %0d axes took the gain path, %0d %s",
                 tracker.samples, settings_used, tracker.gain_path, tracker.offset_path,
                 "the offset path");
        $display("idle patterns none, sender 75%%, receiver 75%%, both 6%%, %s; %0d mismatches",
                 "long hold-offs", tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
